>>> rtl/ordered_list_deque_engine_defines.svh
// assertion macros shared by the checker of the ordered list engine
// needs nothing else; the including file supplies clock and reset names
`ifndef ORDERED_LIST_DEQUE_ENGINE_DEFINES_SVH
`define ORDERED_LIST_DEQUE_ENGINE_DEFINES_SVH

// same-cycle implication, quiet while reset is asserted
`define OLDE_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error("ordered list engine: same-cycle check failed");

// next-cycle implication, quiet while reset is asserted
`define OLDE_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error("ordered list engine: next-cycle check failed");

`endif

>>> rtl/olde_pkg.sv
// types, request codes and status codes of the ordered list engine
// used by the cell, the top level and the checker; depends on nothing
package olde_pkg;

    localparam int REQ_TYPE_W  = 3;
    localparam int REQ_VALUE_W = 32;
    localparam int STATUS_W    = 2;
    localparam int LEN_W       = 5;

    // request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_INS_FRONT = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_INS_BACK  = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_DELETE    = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_SEARCH    = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR     = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0]  req_type;
        logic [REQ_VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic                found;
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    list_length;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_APPLY
    } t_state;

    // per-cell command from the sequencer
    typedef struct packed {
        logic capture;
        logic load_new;
        logic take_prev;
        logic take_next;
    } t_cell_cmd;

endpackage

>>> rtl/olde_cell.sv
// one storage cell of the ordered list: holds an entry and its compare flag
// depends on olde_pkg for the cell command struct
module olde_cell
    import olde_pkg::*;
#(
    parameter int ValueWidth = 32
) (
    input  logic                  i_clk,
    input  t_cell_cmd             i_cmd,
    input  logic [ValueWidth-1:0] i_key,
    input  logic [ValueWidth-1:0] i_prev_value,
    input  logic [ValueWidth-1:0] i_next_value,
    output logic [ValueWidth-1:0] o_value,
    output logic                  o_hit
);

    logic [ValueWidth-1:0] r_value;
    logic [ValueWidth-1:0] n_value;
    logic                  r_hit;

    // entry source: new value, neighbour towards the front or towards the back
    always_comb begin
        n_value = r_value;
        if (i_cmd.load_new) begin
            n_value = i_key;
        end else if (i_cmd.take_prev) begin
            n_value = i_prev_value;
        end else if (i_cmd.take_next) begin
            n_value = i_next_value;
        end
    end

    // entry and compare flag registers
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (i_cmd.capture) begin
            r_hit <= (r_value == i_key);
        end
    end

    assign o_value = r_value;
    assign o_hit   = r_hit;

endmodule

>>> rtl/ordered_list_deque_engine.sv
// Ordered list engine: holds up to MaxEntries values in a row of cells, front in
// cell 0. Each request passes through the idle, match and apply states: the
// request is captured, every cell then compares its entry with the key in
// parallel, and the cells shift or load to insert or delete and the response
// is registered. New requests are stalled from the match state until the apply
// step of the current one is done. A finished response waits in the output
// register while the next request is taken in; the apply step of that request
// waits until the output register is free. No clearing pass is needed after
// reset.
// depends on olde_pkg and olde_cell
module ordered_list_deque_engine
    import olde_pkg::*;
#(
    parameter int MaxEntries = 16,
    parameter int ValueWidth = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    localparam int CntW = $clog2(MaxEntries + 1);

    t_state                r_state;
    t_state                n_state;
    t_req                  r_req;
    t_rsp                  r_rsp;
    t_rsp                  n_rsp;
    logic                  r_out_valid;
    logic [CntW-1:0]       r_count;
    logic [CntW-1:0]       n_count;

    logic [ValueWidth+REQ_VALUE_W-1:0] key_ext;
    logic [ValueWidth-1:0]             key;
    logic [CntW+LEN_W-1:0]             len_ext;

    logic [ValueWidth-1:0] cell_value [MaxEntries];
    t_cell_cmd             cmd        [MaxEntries];
    logic [MaxEntries-1:0] hit;
    logic [MaxEntries-1:0] live;
    logic [MaxEntries-1:0] is_last;
    logic [MaxEntries-1:0] is_tail;
    logic [MaxEntries-1:0] live_hit;
    logic [MaxEntries-1:0] mid_hit;
    logic [MaxEntries-1:0] mid_pre;

    logic capture;
    logic apply;
    logic full;
    logic empty;
    logic front_hit;
    logic back_hit;
    logic ins_front;
    logic ins_back;
    logic del_front;
    logic del_mid;

    // key is the low bits of the value field, zero-extended where wider
    assign key_ext = {{ValueWidth{1'b0}}, r_req.value};
    assign key     = key_ext[ValueWidth-1:0];

    // position flags of each cell against the current length
    for (genvar g = 0; g < MaxEntries; g++) begin : g_pos
        assign live[g]    = (CntW'(g) < r_count);
        assign is_tail[g] = (CntW'(g) == r_count);
        assign is_last[g] = (CntW'(g + 1) == r_count);
    end

    assign full      = (r_count == CntW'(MaxEntries));
    assign empty     = (r_count == '0);
    assign live_hit  = hit & live;
    assign front_hit = live_hit[0];
    assign back_hit  = |(live_hit & is_last);

    // middle matches exclude the front and the back entry
    always_comb begin
        mid_hit    = live_hit & ~is_last;
        mid_hit[0] = 1'b0;
    end

    // prefix or towards the back: cells at and behind the earliest middle match
    always_comb begin
        mid_pre = mid_hit;
        for (int d = 1; d < MaxEntries; d = d * 2) begin
            mid_pre = mid_pre | (mid_pre << d);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_stall = 1'b1;
        capture = 1'b0;
        apply   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
            end
            S_MATCH: begin
                capture = 1'b1;
            end
            S_APPLY: begin
                apply = !r_out_valid || !i_stall;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    // request decode: list update and response
    always_comb begin
        n_count       = r_count;
        n_rsp.found   = 1'b0;
        n_rsp.status  = ST_OK;
        ins_front     = 1'b0;
        ins_back      = 1'b0;
        del_front     = 1'b0;
        del_mid       = 1'b0;
        case (r_req.req_type)
            REQ_INS_FRONT: begin
                if (full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    ins_front = 1'b1;
                    n_count   = CntW'(r_count + 1'b1);
                end
            end
            REQ_INS_BACK: begin
                if (full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    ins_back = 1'b1;
                    n_count  = CntW'(r_count + 1'b1);
                end
            end
            REQ_DELETE: begin
                if (empty) begin
                    n_rsp.status = ST_EMPTY;
                end else if (front_hit) begin
                    del_front   = 1'b1;
                    n_rsp.found = 1'b1;
                    n_count     = CntW'(r_count - 1'b1);
                end else if (back_hit) begin
                    n_rsp.found = 1'b1;
                    n_count     = CntW'(r_count - 1'b1);
                end else if (|mid_hit) begin
                    del_mid     = 1'b1;
                    n_rsp.found = 1'b1;
                    n_count     = CntW'(r_count - 1'b1);
                end else begin
                    n_rsp.status = ST_MISS;
                end
            end
            REQ_SEARCH: begin
                if (empty) begin
                    n_rsp.status = ST_EMPTY;
                end else if (|live_hit) begin
                    n_rsp.found = 1'b1;
                end else begin
                    n_rsp.status = ST_MISS;
                end
            end
            REQ_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        len_ext           = {{LEN_W{1'b0}}, n_count};
        n_rsp.list_length = len_ext[LEN_W-1:0];
    end

    // row of cells with neighbour links
    for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
        logic [ValueWidth-1:0] prev_value;
        logic [ValueWidth-1:0] next_value;

        if (g == 0) begin : g_first
            assign prev_value = key;
        end else begin : g_inner_prev
            assign prev_value = cell_value[g-1];
        end

        if (g == MaxEntries - 1) begin : g_last
            assign next_value = cell_value[g];
        end else begin : g_inner_next
            assign next_value = cell_value[g+1];
        end

        assign cmd[g].capture   = capture;
        assign cmd[g].load_new  = apply && ((ins_front && (g == 0)) ||
                                            (ins_back && is_tail[g]));
        assign cmd[g].take_prev = apply && ins_front && (g != 0);
        assign cmd[g].take_next = apply && (del_front || (del_mid && mid_pre[g]));

        olde_cell #(
            .ValueWidth (ValueWidth)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmd        (cmd[g]),
            .i_key        (key),
            .i_prev_value (prev_value),
            .i_next_value (next_value),
            .o_value      (cell_value[g]),
            .o_hit        (hit[g])
        );
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (apply) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and response payload registers
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_req <= i_req;
        end
        if (apply) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

endmodule

>>> rtl/olde_checker.sv
// port-level checks of the ordered list engine and their binding
// depends on olde_pkg and ordered_list_deque_engine_defines.svh
`include "ordered_list_deque_engine_defines.svh"

module olde_checker
    import olde_pkg::*;
#(
    parameter int MaxEntries = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_stall,
    input t_req i_req,
    input logic i_rsp_valid,
    input logic i_rsp_stall,
    input t_rsp i_rsp
);

    localparam logic [LEN_W+31:0] MaxExt = (LEN_W + 32)'(MaxEntries);

    // engine is busy in the cycle after a transaction is taken in
    `OLDE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req_valid && !i_req_stall, i_req_stall)

    // a hit is always reported with an ok status
    `OLDE_ASSERT_NOW(a_found_is_ok, i_clk, i_rst_n, i_rsp_valid && i_rsp.found, i_rsp.status == ST_OK)

    // a rejected insert means the list is at capacity
    `OLDE_ASSERT_NOW(a_full_at_capacity, i_clk, i_rst_n, i_rsp_valid && (i_rsp.status == ST_FULL), i_rsp.list_length == MaxExt[LEN_W-1:0])

    // an empty status reports an empty list and no hit
    `OLDE_ASSERT_NOW(a_empty_len_zero, i_clk, i_rst_n, i_rsp_valid && (i_rsp.status == ST_EMPTY), (i_rsp.list_length == '0) && !i_rsp.found)

endmodule

bind ordered_list_deque_engine olde_checker #(
    .MaxEntries (MaxEntries)
) u_olde_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_valid),
    .i_req_stall (o_stall),
    .i_req       (i_req),
    .i_rsp_valid (o_valid),
    .i_rsp_stall (i_stall),
    .i_rsp       (o_rsp)
);
